### src/mspdf_pkg.sv
package mspdf_pkg;

    // frame store geometry
    localparam int FRAME_CAPACITY = 264;
    localparam int ADDR_W = $clog2(FRAME_CAPACITY);
    localparam int POS_W = $clog2(FRAME_CAPACITY + 1);

    // frame layout
    localparam int FRAME_OVERHEAD = 6;
    localparam int LEN_POS = 3;
    localparam int CMD_POS = 4;

    // item operations
    localparam logic [1:0] OP_FEED = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_GOOD = 3'd1;
    localparam logic [2:0] ST_HDR = 3'd2;
    localparam logic [2:0] ST_CKSUM = 3'd3;
    localparam logic [2:0] ST_LONG = 3'd4;

    // header bytes
    localparam logic [7:0] SYNC_DOLLAR = 8'h24;
    localparam logic [7:0] SYNC_M = 8'h4D;
    localparam logic [7:0] DIR_REQ = 8'h3C;
    localparam logic [7:0] DIR_RESP = 8'h3E;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] frame_length;
        logic [7:0] command;
        logic       is_response;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

endpackage

### src/mspdf_ram.sv
module mspdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 264,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mspdf_parser.sv
module mspdf_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 feed,
    input  logic                 clear,
    input  logic [7:0]           data_byte,
    output mspdf_pkg::store_wr_t wr,
    output mspdf_pkg::result_t   res
);
    import mspdf_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_DOLLAR  = 5'b00010,
        PH_M       = 5'b00100,
        PH_DIR     = 5'b01000,
        PH_COLLECT = 5'b10000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [8:0]       total_reg, total_next;
    logic [7:0]       xor_reg, xor_next;
    logic             dir_reg, dir_next;
    logic [7:0]       cmd_reg, cmd_next;

    logic [8:0]       len_total;
    logic [POS_W-1:0] pos_inc;

    assign len_total = 9'(FRAME_OVERHEAD) + {1'b0, data_byte};
    assign pos_inc = pos_reg + POS_W'(1);

    // header walk and payload collection
    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        total_next = total_reg;
        xor_next = xor_reg;
        dir_next = dir_reg;
        cmd_next = cmd_reg;
        wr.en = 1'b0;
        wr.addr = '0;
        wr.data = data_byte;
        res = '0;

        if (clear)
        begin
            phase_next = PH_IDLE;
            pos_next = '0;
            total_next = '0;
            xor_next = '0;
            dir_next = 1'b0;
        end
        else if (feed)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (data_byte == SYNC_DOLLAR)
                    begin
                        wr.en = 1'b1;
                        wr.addr = ADDR_W'(0);
                        pos_next = POS_W'(1);
                        phase_next = PH_DOLLAR;
                    end
                end
                PH_DOLLAR:
                begin
                    if (data_byte == SYNC_M)
                    begin
                        wr.en = 1'b1;
                        wr.addr = ADDR_W'(1);
                        pos_next = POS_W'(2);
                        phase_next = PH_M;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res.status = ST_HDR;
                    end
                end
                PH_M:
                begin
                    if (data_byte == DIR_REQ || data_byte == DIR_RESP)
                    begin
                        wr.en = 1'b1;
                        wr.addr = ADDR_W'(2);
                        pos_next = POS_W'(3);
                        dir_next = (data_byte == DIR_RESP);
                        phase_next = PH_DIR;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res.status = ST_HDR;
                    end
                end
                PH_DIR:
                begin
                    if (32'(len_total) > FRAME_CAPACITY)
                    begin
                        res.status = ST_LONG;
                        res.frame_length = len_total;
                        res.is_response = dir_reg;
                        phase_next = PH_IDLE;
                        pos_next = '0;
                        total_next = '0;
                        xor_next = '0;
                        dir_next = 1'b0;
                    end
                    else
                    begin
                        wr.en = 1'b1;
                        wr.addr = ADDR_W'(LEN_POS);
                        total_next = len_total;
                        xor_next = data_byte;
                        pos_next = POS_W'(CMD_POS);
                        phase_next = PH_COLLECT;
                    end
                end
                PH_COLLECT:
                begin
                    wr.en = 1'b1;
                    wr.addr = ADDR_W'(pos_reg);
                    pos_next = pos_inc;
                    // command byte kept aside for the completion report
                    if (32'(pos_reg) == CMD_POS)
                    begin
                        cmd_next = data_byte;
                    end
                    if (32'(pos_inc) >= 32'(total_reg))
                    begin
                        res.frame_length = total_reg;
                        res.command = cmd_reg;
                        res.is_response = dir_reg;
                        if (xor_reg == data_byte)
                        begin
                            res.status = ST_GOOD;
                            phase_next = PH_IDLE;
                            pos_next = '0;
                        end
                        else
                        begin
                            res.status = ST_CKSUM;
                            phase_next = PH_IDLE;
                            pos_next = '0;
                            total_next = '0;
                            xor_next = '0;
                            dir_next = 1'b0;
                        end
                    end
                    else
                    begin
                        xor_next = xor_reg ^ data_byte;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    pos_next = '0;
                    total_next = '0;
                    xor_next = '0;
                    dir_next = 1'b0;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg <= '0;
            total_reg <= '0;
            xor_reg <= '0;
            dir_reg <= 1'b0;
            cmd_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            total_reg <= total_next;
            xor_reg <= xor_next;
            dir_reg <= dir_next;
            cmd_reg <= cmd_next;
        end
    end

endmodule

### src/msp_v1_frame_deframer.sv
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------------
// in       | in_valid / in_ready | op, data_byte, read_index
// out      | out_valid/out_ready | status, frame_length, command, is_response,
//          |                     | read_byte
//
// one item per cycle sustained while the output is not stalled; each result passes
// through the read stage, which loads with the frame store read port when its item
// is taken, and then through the output register.
// reset clears the parser and both pipeline stages; the frame store keeps no reset.
// a stalled output holds the read stage, and the input stalls only when both
// the read stage and the output register are full.
module msp_v1_frame_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic [8:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [8:0] frame_length,
    output logic [7:0] command,
    output logic       is_response,
    output logic [7:0] read_byte
);
    import mspdf_pkg::*;

    logic      accept;
    logic      s1_move;
    store_wr_t wr;
    result_t   res;
    logic [7:0] ram_rdata;
    logic       rd_hit;

    logic    s1_valid_reg, s1_valid_next;
    result_t s1_res_reg;
    logic    s1_hit_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic [7:0] out_byte_reg;

    // handshake
    assign s1_move = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept = in_valid && in_ready;
    assign rd_hit = (op == OP_READ) && (32'(read_index) < FRAME_CAPACITY);

    mspdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (accept && (op == OP_FEED)),
        .clear     (accept && (op == OP_CLEAR)),
        .data_byte (data_byte),
        .wr        (wr),
        .res       (res)
    );

    mspdf_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept && rd_hit),
        .raddr (ADDR_W'(read_index)),
        .rdata (ram_rdata)
    );

    // stage valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
            s1_hit_reg <= rd_hit;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_res_reg <= s1_res_reg;
            out_byte_reg <= s1_hit_reg ? ram_rdata : 8'h00;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_res_reg.status;
    assign frame_length = out_res_reg.frame_length;
    assign command = out_res_reg.command;
    assign is_response = out_res_reg.is_response;
    assign read_byte = out_byte_reg;

endmodule
